>>> hdl/ggv_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command package
// Shared widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ggv_pkg;

  localparam int ANGLE_STAGES_DEF = 16;
  localparam int POS_W   = 48;   // position fields
  localparam int OFS_W   = 49;   // goal minus robot
  localparam int ROT_W   = 16;   // rotation entries
  localparam int FX_W    = 54;   // rotated offsets
  localparam int ANG_W   = 18;   // angles, q13
  localparam int CFG_W   = 24;   // widest register
  localparam int IDX_W   = 4;
  localparam int BRG_W   = 57;   // CORDIC width for the bearing
  localparam int YAW_W   = 35;   // CORDIC width for the yaw
  localparam int FXC_W   = 34;   // fx after saturation to +-2^32

  localparam logic signed [ANG_W-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [ANG_W:0]   TWO_PI_Q13 = 19'sd51472;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_FWD  = 4'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_TURN = 4'd1;
  localparam logic [IDX_W-1:0] REG_LIM_FWD   = 4'd2;
  localparam logic [IDX_W-1:0] REG_LIM_REV   = 4'd3;
  localparam logic [IDX_W-1:0] REG_NEAR      = 4'd4;
  localparam logic [IDX_W-1:0] REG_ARRIVE    = 4'd5;
  localparam logic [IDX_W-1:0] REG_HEAD_TOL  = 4'd6;
  localparam logic [IDX_W-1:0] REG_FINAL_HD  = 4'd7;

  // Sideband that travels alongside the angle units
  typedef struct packed {
    logic                    valid;
    logic                    path;
    logic                    near;
    logic                    arrive;
    logic signed [FX_W-1:0]  fx;
  } side_t;

  // arctan(2^-i) in q13
  function automatic logic [12:0] atan_q13(input int i);
    logic [12:0] v;
    case (i)
      0:       v = 13'd6434;
      1:       v = 13'd3798;
      2:       v = 13'd2007;
      3:       v = 13'd1019;
      4:       v = 13'd511;
      5:       v = 13'd256;
      6:       v = 13'd128;
      7:       v = 13'd64;
      8:       v = 13'd32;
      9:       v = 13'd16;
      10:      v = 13'd8;
      11:      v = 13'd4;
      12:      v = 13'd2;
      13:      v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/go_to_goal_velocity_command_unit.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command unit
// Path: offset rotation, then the two CORDIC units, then the command stage.
// Throughput: one item per cycle; busy is never raised and the receiver cannot
// stall, so results stream out one per accepted item.
// Depth is set by the two parallel CORDIC pipelines, one stage per rotation.
// Reset clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_command_unit #(
  parameter int ANGLE_STAGES = ggv_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_path_present,
  input  logic signed [47:0]                  in_target_x,
  input  logic signed [47:0]                  in_target_y,
  input  logic signed [47:0]                  in_robot_x,
  input  logic signed [47:0]                  in_robot_y,
  input  logic signed [15:0]                  in_heading_cos,
  input  logic signed [15:0]                  in_heading_sin,
  input  logic                                cfg_we,
  input  logic [ggv_pkg::IDX_W-1:0]           cfg_index,
  input  logic [ggv_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  output logic signed [20:0]                  out_forward_speed,
  output logic signed [17:0]                  out_turn_rate,
  output logic                                out_goal_reached
);

  localparam int LAT = ANGLE_STAGES + 2;

  assign busy = 1'b0;

  // configuration registers
  logic [13:0]        gain_fwd_r, gain_turn_r;
  logic [19:0]        lim_fwd_r, lim_rev_r;
  logic [23:0]        near_r, arrive_r;
  logic [14:0]        tol_r;
  logic signed [15:0] final_hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_fwd_r  <= 14'd3277;
      gain_turn_r <= 14'd4096;
      lim_fwd_r   <= 20'd131072;
      lim_rev_r   <= 20'd131072;
      near_r      <= 24'd6554;
      arrive_r    <= 24'd19661;
      tol_r       <= 15'd2860;
      final_hd_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ggv_pkg::REG_GAIN_FWD:  gain_fwd_r  <= cfg_data[13:0];
        ggv_pkg::REG_GAIN_TURN: gain_turn_r <= cfg_data[13:0];
        ggv_pkg::REG_LIM_FWD:   lim_fwd_r   <= cfg_data[19:0];
        ggv_pkg::REG_LIM_REV:   lim_rev_r   <= cfg_data[19:0];
        ggv_pkg::REG_NEAR:      near_r      <= cfg_data[23:0];
        ggv_pkg::REG_ARRIVE:    arrive_r    <= cfg_data[23:0];
        ggv_pkg::REG_HEAD_TOL:  tol_r       <= cfg_data[14:0];
        ggv_pkg::REG_FINAL_HD:  final_hd_r  <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // offset rotation and distance tests
  logic                                rv, rp, rnear, rarr;
  logic signed [ggv_pkg::FX_W-1:0]     fx, fy;
  logic signed [ggv_pkg::ROT_W-1:0]    rc, rs;

  ggv_rotate u_rotate (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start && !busy),
    .in_path       (in_path_present),
    .tx            (in_target_x),
    .ty            (in_target_y),
    .rx            (in_robot_x),
    .ry            (in_robot_y),
    .c_in          (in_heading_cos),
    .s_in          (in_heading_sin),
    .near_radius   (near_r),
    .arrive_radius (arrive_r),
    .out_valid     (rv),
    .out_path      (rp),
    .out_near      (rnear),
    .out_arrive    (rarr),
    .out_fx        (fx),
    .out_fy        (fy),
    .out_c         (rc),
    .out_s         (rs)
  );

  // bearing and yaw, in parallel
  logic signed [ggv_pkg::ANG_W-1:0] bearing, yaw;

  ggv_cordic #(.W(ggv_pkg::BRG_W), .STAGES(ANGLE_STAGES)) u_bearing (
    .clk   (clk),
    .x_in  (ggv_pkg::BRG_W'(fx)),
    .y_in  (ggv_pkg::BRG_W'(fy)),
    .angle (bearing)
  );

  ggv_cordic #(.W(ggv_pkg::YAW_W), .STAGES(ANGLE_STAGES)) u_yaw (
    .clk   (clk),
    .x_in  (ggv_pkg::YAW_W'(rc) <<< 16),
    .y_in  (ggv_pkg::YAW_W'(rs) <<< 16),
    .angle (yaw)
  );

  // sideband delay matching the angle units
  ggv_pkg::side_t side_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0].valid <= rv;
      for (int i = 1; i < LAT; i++) begin
        side_r[i].valid <= side_r[i-1].valid;
      end
    end
    side_r[0].path   <= rp;
    side_r[0].near   <= rnear;
    side_r[0].arrive <= rarr;
    side_r[0].fx     <= fx;
    for (int i = 1; i < LAT; i++) begin
      side_r[i].path   <= side_r[i-1].path;
      side_r[i].near   <= side_r[i-1].near;
      side_r[i].arrive <= side_r[i-1].arrive;
      side_r[i].fx     <= side_r[i-1].fx;
    end
  end

  // error, gains, limits
  ggv_command u_command (
    .clk               (clk),
    .rst_n             (rst_n),
    .side              (side_r[LAT-1]),
    .bearing           (bearing),
    .yaw               (yaw),
    .gain_forward      (gain_fwd_r),
    .gain_turn         (gain_turn_r),
    .limit_forward     (lim_fwd_r),
    .limit_reverse     (lim_rev_r),
    .heading_tolerance (tol_r),
    .final_heading     (final_hd_r),
    .out_valid         (out_valid),
    .out_forward_speed (out_forward_speed),
    .out_turn_rate     (out_turn_rate),
    .out_goal_reached  (out_goal_reached)
  );

endmodule

>>> hdl/ggv_rotate.sv
// ----------------------------------------------------------------------------
// Offset rotation
// Forms goal-minus-robot, rotates it into the robot frame with split
// products, and runs both squared-distance tests. Three register stages.
// ----------------------------------------------------------------------------
module ggv_rotate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_path,
  input  logic signed [ggv_pkg::POS_W-1:0]     tx,
  input  logic signed [ggv_pkg::POS_W-1:0]     ty,
  input  logic signed [ggv_pkg::POS_W-1:0]     rx,
  input  logic signed [ggv_pkg::POS_W-1:0]     ry,
  input  logic signed [ggv_pkg::ROT_W-1:0]     c_in,
  input  logic signed [ggv_pkg::ROT_W-1:0]     s_in,
  input  logic [23:0]                          near_radius,
  input  logic [23:0]                          arrive_radius,
  output logic                                 out_valid,
  output logic                                 out_path,
  output logic                                 out_near,
  output logic                                 out_arrive,
  output logic signed [ggv_pkg::FX_W-1:0]      out_fx,
  output logic signed [ggv_pkg::FX_W-1:0]      out_fy,
  output logic signed [ggv_pkg::ROT_W-1:0]     out_c,
  output logic signed [ggv_pkg::ROT_W-1:0]     out_s
);

  localparam int OW = ggv_pkg::OFS_W;
  localparam int RW = ggv_pkg::ROT_W;
  localparam int PW = 41;   // 16 x 25 product
  localparam int SW = 42;   // sum of two products

  // stage 1: offsets
  logic                 v1_r, p1_r;
  logic signed [OW-1:0] dx_r, dy_r;
  logic signed [RW-1:0] c1_r, s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    p1_r <= in_path;
    dx_r <= OW'(tx) - OW'(rx);
    dy_r <= OW'(ty) - OW'(ry);
    c1_r <= c_in;
    s1_r <= s_in;
  end

  // stage 2: partial products and squares
  logic signed [24:0] dxh, dxl, dyh, dyl;
  logic               dx_small, dy_small;
  assign dxh = dx_r[48:24];
  assign dyh = dy_r[48:24];
  assign dxl = $signed({1'b0, dx_r[23:0]});
  assign dyl = $signed({1'b0, dy_r[23:0]});
  assign dx_small = (dxh == '0) || (dxh == '1 && dx_r[23:0] != '0);
  assign dy_small = (dyh == '0) || (dyh == '1 && dy_r[23:0] != '0);

  logic                 v2_r, p2_r, sm2_r;
  logic signed [PW-1:0] cdxh_r, cdxl_r, sdyh_r, sdyl_r;
  logic signed [PW-1:0] cdyh_r, cdyl_r, sdxh_r, sdxl_r;
  logic [47:0]          dx2_r, dy2_r, near2_r, arr2_r;
  logic signed [RW-1:0] c2_r, s2_r;
  logic signed [49:0]   dx2w, dy2w;

  assign dx2w = $signed(dx_r[24:0]) * $signed(dx_r[24:0]);
  assign dy2w = $signed(dy_r[24:0]) * $signed(dy_r[24:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    p2_r    <= p1_r;
    sm2_r   <= dx_small && dy_small;
    cdxh_r  <= PW'(c1_r * dxh);
    cdxl_r  <= PW'(c1_r * dxl);
    sdyh_r  <= PW'(s1_r * dyh);
    sdyl_r  <= PW'(s1_r * dyl);
    cdyh_r  <= PW'(c1_r * dyh);
    cdyl_r  <= PW'(c1_r * dyl);
    sdxh_r  <= PW'(s1_r * dxh);
    sdxl_r  <= PW'(s1_r * dxl);
    dx2_r   <= dx2w[47:0];
    dy2_r   <= dy2w[47:0];
    near2_r <= near_radius * near_radius;
    arr2_r  <= arrive_radius * arrive_radius;
    c2_r    <= c1_r;
    s2_r    <= s1_r;
  end

  // stage 3: recombine and compare
  logic signed [SW-1:0] hx, lx, hy, ly;
  logic [48:0]          d2;
  assign hx = SW'(cdxh_r) + SW'(sdyh_r);
  assign lx = SW'(cdxl_r) + SW'(sdyl_r);
  assign hy = SW'(cdyh_r) - SW'(sdxh_r);
  assign ly = SW'(cdyl_r) - SW'(sdxl_r);
  assign d2 = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2_r;
    end
    out_path   <= p2_r;
    out_fx     <= (ggv_pkg::FX_W'(hx) <<< 10) + ggv_pkg::FX_W'(lx >>> 14);
    out_fy     <= (ggv_pkg::FX_W'(hy) <<< 10) + ggv_pkg::FX_W'(ly >>> 14);
    out_near   <= sm2_r && (d2 < {1'b0, near2_r});
    out_arrive <= sm2_r && (d2 < {1'b0, arr2_r});
    out_c      <= c2_r;
    out_s      <= s2_r;
  end

endmodule

>>> hdl/ggv_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) in q13: one fold stage, one stage per rotation, one stage
// for the fold correction and clamp.
// ----------------------------------------------------------------------------
module ggv_cordic #(
  parameter int W      = ggv_pkg::BRG_W,
  parameter int STAGES = ggv_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                clk,
  input  logic signed [W-1:0]                 x_in,
  input  logic signed [W-1:0]                 y_in,
  output logic signed [ggv_pkg::ANG_W-1:0]    angle
);

  localparam int AW = ggv_pkg::ANG_W;

  logic signed [W-1:0]  x_r    [0:STAGES];
  logic signed [W-1:0]  y_r    [0:STAGES];
  logic signed [AW-1:0] z_r    [0:STAGES];
  logic signed [AW-1:0] base_r [0:STAGES];
  logic                 zero_r [0:STAGES];

  // fold into the right half plane
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    z_r[0]    <= '0;
    if (x_in < 0) begin
      x_r[0]    <= -x_in;
      y_r[0]    <= -y_in;
      base_r[0] <= (y_in < 0) ? -ggv_pkg::PI_Q13 : ggv_pkg::PI_Q13;
    end else begin
      x_r[0]    <= x_in;
      y_r[0]    <= y_in;
      base_r[0] <= '0;
    end
  end

  // rotation stages
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = AW'(ggv_pkg::atan_q13(i));
    always_ff @(posedge clk) begin
      base_r[i+1] <= base_r[i];
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] < 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN;
      end
    end
  end

  // correction and clamp to +-pi
  logic signed [AW:0] sum;
  assign sum = (AW+1)'(base_r[STAGES]) + (AW+1)'(z_r[STAGES]);

  always_ff @(posedge clk) begin
    if (zero_r[STAGES]) begin
      angle <= '0;
    end else if (sum > (AW+1)'(ggv_pkg::PI_Q13)) begin
      angle <= ggv_pkg::PI_Q13;
    end else if (sum < -(AW+1)'(ggv_pkg::PI_Q13)) begin
      angle <= -ggv_pkg::PI_Q13;
    end else begin
      angle <= AW'(sum);
    end
  end

endmodule

>>> hdl/ggv_command.sv
// ----------------------------------------------------------------------------
// Command stage
// Picks and wraps the heading error, tests arrival, applies the gains and
// limits. Three register stages ending in the output registers.
// ----------------------------------------------------------------------------
module ggv_command (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ggv_pkg::side_t                      side,
  input  logic signed [ggv_pkg::ANG_W-1:0]    bearing,
  input  logic signed [ggv_pkg::ANG_W-1:0]    yaw,
  input  logic [13:0]                         gain_forward,
  input  logic [13:0]                         gain_turn,
  input  logic [19:0]                         limit_forward,
  input  logic [19:0]                         limit_reverse,
  input  logic [14:0]                         heading_tolerance,
  input  logic signed [15:0]                  final_heading,
  output logic                                out_valid,
  output logic signed [20:0]                  out_forward_speed,
  output logic signed [17:0]                  out_turn_rate,
  output logic                                out_goal_reached
);

  localparam int AW  = ggv_pkg::ANG_W;
  localparam int FW  = ggv_pkg::FX_W;
  localparam int CW  = ggv_pkg::FXC_W;
  localparam logic signed [FW-1:0] FX_HI = FW'(64'sd4294967296);

  // stage A: heading error, fx saturation
  logic signed [AW:0]   diff, wrapped;
  logic signed [CW-1:0] fxc;
  assign diff = (AW+1)'(final_heading) - (AW+1)'(yaw);
  always_comb begin
    if (diff > (AW+1)'(ggv_pkg::PI_Q13)) begin
      wrapped = diff - ggv_pkg::TWO_PI_Q13;
    end else if (diff < -(AW+1)'(ggv_pkg::PI_Q13)) begin
      wrapped = diff + ggv_pkg::TWO_PI_Q13;
    end else begin
      wrapped = diff;
    end
    if (side.fx > FX_HI) begin
      fxc = CW'(FX_HI);
    end else if (side.fx < -FX_HI) begin
      fxc = CW'(-FX_HI);
    end else begin
      fxc = CW'(side.fx);
    end
  end

  logic                 va_r, pa_r, arra_r;
  logic signed [AW-1:0] err_r;
  logic signed [CW-1:0] fxc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= side.valid;
    end
    pa_r   <= side.path;
    arra_r <= side.arrive;
    err_r  <= side.near ? AW'(wrapped) : bearing;
    fxc_r  <= fxc;
  end

  // stage B: gains and arrival
  logic [AW-1:0] mag;
  assign mag = err_r[AW-1] ? AW'(-err_r) : AW'(err_r);

  logic                 vb_r, pb_r, goal_r;
  logic signed [CW+14:0] vp_r;
  logic signed [AW+14:0] wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    pb_r   <= pa_r;
    goal_r <= arra_r && (mag < AW'(heading_tolerance));
    vp_r   <= (CW+15)'(fxc_r * $signed({1'b0, gain_forward}));
    wp_r   <= (AW+15)'(err_r * $signed({1'b0, gain_turn}));
  end

  // stage C: scale, limit, output registers
  logic signed [CW+2:0] vs;
  logic signed [AW+2:0] ws;
  logic signed [20:0]   v_lim;
  logic signed [17:0]   w_lim;
  assign vs = (CW+3)'(vp_r >>> 12);
  assign ws = (AW+3)'(wp_r >>> 12);
  always_comb begin
    if (vs > (CW+3)'($signed({1'b0, limit_forward}))) begin
      v_lim = $signed({1'b0, limit_forward});
    end else if (vs < -(CW+3)'($signed({1'b0, limit_reverse}))) begin
      v_lim = -$signed({1'b0, limit_reverse});
    end else begin
      v_lim = 21'(vs);
    end
    if (ws > (AW+3)'(18'sh1ffff)) begin
      w_lim = 18'sh1ffff;
    end else if (ws < -(AW+3)'(19'sh20000)) begin
      w_lim = -18'sh20000;
    end else begin
      w_lim = 18'(ws);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vb_r;
    end
    if (!pb_r || goal_r) begin
      out_forward_speed <= '0;
      out_turn_rate     <= '0;
    end else begin
      out_forward_speed <= v_lim;
      out_turn_rate     <= w_lim;
    end
    out_goal_reached <= pb_r && goal_r;
  end

endmodule
